// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked when not in reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked when not in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/b64_pkg.sv
// types, constants and character tables of the base64 codec
// no dependencies
package b64_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // one group's worth of results, bytes go out from index 0 up
  typedef struct packed {
    logic [1:0]      cnt_m1;
    logic [3:0][7:0] bytes;
    logic            fin_last;
    logic            fin_bad;
  } b64_job_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64_sextet_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [8:0] pos;
    pos = {~v, 3'b000};
    return ALPHABET[pos +: 8];
  endfunction

  function automatic b64_sextet_t b64_sextet(input logic [7:0] c);
    b64_sextet_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c + 8'd4);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/b64_front.sv
// front end: accepts items, gathers groups and turns each finished group into a job
// depends on b64_pkg
module b64_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              push,
  output b64_pkg::b64_job_t job
);

  logic        decode_mode;
  logic [23:0] group_bits;
  logic [1:0]  group_fill;
  logic        drop_rest;

  logic [23:0] group_bits_next;
  logic [1:0]  group_fill_next;
  logic        drop_rest_next;
  logic        job_valid;

  logic [23:0]         enc_bits;
  logic [1:0]          enc_fill;
  logic [23:0]         dec_bits;
  b64_pkg::b64_sextet_t sx;

  always_comb begin
    enc_bits = group_bits;
    enc_fill = group_fill;
    if (group_fill == 2'd3) begin
      enc_bits = '0;
      enc_fill = 2'd0;
    end
    case (enc_fill)
      2'd0:    enc_bits = enc_bits | {in_byte, 16'd0};
      2'd1:    enc_bits = enc_bits | {8'd0, in_byte, 8'd0};
      default: enc_bits = enc_bits | {16'd0, in_byte};
    endcase

    sx = b64_pkg::b64_sextet(in_byte);
    case (group_fill)
      2'd0:    dec_bits = group_bits | {sx.value, 18'd0};
      2'd1:    dec_bits = group_bits | {6'd0, sx.value, 12'd0};
      2'd2:    dec_bits = group_bits | {12'd0, sx.value, 6'd0};
      default: dec_bits = group_bits | {18'd0, sx.value};
    endcase

    group_bits_next = group_bits;
    group_fill_next = group_fill;
    drop_rest_next  = drop_rest;
    job_valid       = 1'b0;
    job             = '0;

    if (!decode_mode) begin
      drop_rest_next = 1'b0;
      if (enc_fill != 2'd2 && !in_last) begin
        group_bits_next = enc_bits;
        group_fill_next = enc_fill + 2'd1;
      end else begin
        job_valid       = 1'b1;
        job.cnt_m1      = 2'd3;
        job.bytes[0]    = b64_pkg::b64_char(enc_bits[23:18]);
        job.bytes[1]    = b64_pkg::b64_char(enc_bits[17:12]);
        job.bytes[2]    = (enc_fill >= 2'd1) ? b64_pkg::b64_char(enc_bits[11:6])
                                             : b64_pkg::PAD_CHAR;
        job.bytes[3]    = (enc_fill == 2'd2) ? b64_pkg::b64_char(enc_bits[5:0])
                                             : b64_pkg::PAD_CHAR;
        job.fin_last    = in_last;
        group_bits_next = '0;
        group_fill_next = 2'd0;
      end
    end else if (drop_rest) begin
      if (in_last) begin
        drop_rest_next  = 1'b0;
        group_bits_next = '0;
        group_fill_next = 2'd0;
      end
    end else if (in_byte == b64_pkg::PAD_CHAR && group_fill >= 2'd2) begin
      // pad ends the output: one byte after two chars, two after three
      job_valid       = 1'b1;
      job.cnt_m1      = (group_fill == 2'd2) ? 2'd0 : 2'd1;
      job.bytes[0]    = group_bits[23:16];
      job.bytes[1]    = group_bits[15:8];
      job.fin_last    = 1'b1;
      group_bits_next = '0;
      group_fill_next = 2'd0;
      drop_rest_next  = !in_last;
    end else if (!sx.valid || (in_last && group_fill != 2'd3)) begin
      // bad character or short final group
      job_valid       = 1'b1;
      job.cnt_m1      = 2'd0;
      job.fin_last    = 1'b1;
      job.fin_bad     = 1'b1;
      group_bits_next = '0;
      group_fill_next = 2'd0;
      drop_rest_next  = !in_last;
    end else if (group_fill != 2'd3) begin
      group_bits_next = dec_bits;
      group_fill_next = group_fill + 2'd1;
    end else begin
      job_valid       = 1'b1;
      job.cnt_m1      = 2'd2;
      job.bytes[0]    = dec_bits[23:16];
      job.bytes[1]    = dec_bits[15:8];
      job.bytes[2]    = dec_bits[7:0];
      job.fin_last    = in_last;
      group_bits_next = '0;
      group_fill_next = 2'd0;
    end
  end

  assign push = in_fire && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      group_bits  <= '0;
      group_fill  <= 2'd0;
      drop_rest   <= 1'b0;
    end else if (cfg_wr_en) begin
      decode_mode <= cfg_wr_data;
      group_bits  <= '0;
      group_fill  <= 2'd0;
      drop_rest   <= 1'b0;
    end else if (in_fire) begin
      group_bits  <= group_bits_next;
      group_fill  <= group_fill_next;
      drop_rest   <= drop_rest_next;
    end
  end

endmodule

// File: rtl/b64_queue.sv
// job queue between front and back ends
// depends on b64_pkg
module b64_queue #(
  parameter int DEPTH = b64_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64_pkg::b64_job_t wr_job,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output b64_pkg::b64_job_t rd_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  b64_pkg::b64_job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/b64_back.sv
// back end: unrolls jobs into single results behind an output register
// depends on b64_pkg
module b64_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  b64_pkg::b64_job_t q_job,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic [0:0]        m_tuser
);

  b64_pkg::b64_job_t work;
  logic              work_valid;
  logic [1:0]        idx;
  logic              load;
  logic              at_end;

  assign load   = work_valid && (!m_tvalid || m_tready);
  assign at_end = (idx == work.cnt_m1);
  assign pop    = q_valid && (!work_valid || (load && at_end));

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= q_job;
    end
    if (load) begin
      m_tdata    <= work.bytes[idx];
      m_tlast    <= at_end && work.fin_last;
      m_tuser[0] <= at_end && work.fin_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      idx        <= 2'd0;
      m_tvalid   <= 1'b0;
    end else begin
      if (pop) begin
        work_valid <= 1'b1;
        idx        <= 2'd0;
      end else if (load) begin
        work_valid <= !at_end;
        idx        <= at_end ? 2'd0 : idx + 2'd1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/base64_codec.sv
// top level of the streaming base64 codec (standard alphabet, '=' padding)
// depends on b64_pkg, b64_front, b64_queue, b64_back
//
// Encode mode (cfg decode_mode = 0) takes raw bytes on the slave stream and
// sends four characters for every three bytes; a request with s_tlast closes
// the group early and pads it with '=', the fourth character carrying
// m_tlast. Decode mode (decode_mode = 1) takes characters and sends three
// bytes per four; a pad ends the output with one or two bytes (m_tlast set)
// and the rest of the stream up to s_tlast is swallowed. A bad character or
// a short final group gives a single result with data 0, m_tlast and the
// error flag in m_tuser, then also swallows the rest. Writing the mode
// register starts a new stream; write it only while the codec is idle.
// Rate: the front end takes one request per clock as long as the job queue
// has room; the back end sends one result per clock while m_tready is high,
// so in encode mode the output port sets the pace, in decode mode the input
// at one character per cycle. A job passes from the job queue through the
// work register to the output register. Jobs queue up to QUEUE_DEPTH groups.
module base64_codec #(
  parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // mode register
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // decode_mode
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,       // [7:0] in_byte
  input  logic       s_tlast,       // in_last
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,       // [7:0] out_byte
  output logic       m_tlast,       // out_last
  output logic [0:0] m_tuser        // [0] bad_input
);

  logic              q_full;
  logic              in_fire;
  logic              push;
  b64_pkg::b64_job_t front_job;
  logic              q_valid;
  b64_pkg::b64_job_t q_job;
  logic              pop;

  // the front never needs more than one queue slot per request
  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  b64_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_byte     (s_tdata),
    .in_last     (s_tlast),
    .push        (push),
    .job         (front_job)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (front_job),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  b64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/b64_checker.sv
// port-level checks of the base64 codec, bound to the top level
// depends on assert_macros.svh and base64_codec
`include "assert_macros.svh"

module b64_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_wr_en,
  input logic       cfg_wr_data,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [0:0] m_tuser
);

  logic decode_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      decode_mode <= cfg_wr_data;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")
  `ASSERT_SAME(a_err_shape, clk, rst, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 8'd0), "error result not zero and final")
  `ASSERT_SAME(a_enc_no_err, clk, rst, m_tvalid && !decode_mode, !m_tuser[0], "error flag in encode mode")

endmodule

bind base64_codec b64_checker u_b64_checker (.*);

// File: tb/sv/base64_codec_checker.sv
// result checker for the base64 codec testbench: watches both streams and the mode port
// depends on b64_pkg (pad character) and the base64_codec port signals

module base64_codec_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  input  logic [0:0] m_tuser,
  output int         mismatches,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } codec_result_t;

  codec_result_t owed_results[$];

  // shadow of the codec state
  logic        decoding = 1'b0;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_fill = '0;
  logic        dropping = 1'b0;
  int          fail_cnt = 0;

  assign mismatches = fail_cnt;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  // bit 6 set when the character is outside the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
    if (c == 8'h2B) return {1'b0, 6'd62};
    if (c == 8'h2F) return {1'b0, 6'd63};
    return {1'b1, 6'd0};
  endfunction

  task automatic owe(input logic [7:0] data, input logic last, input logic bad);
    owed_results.push_back('{data: data, last: last, bad: bad});
  endtask

  task automatic clear_group();
    grp_bits = '0;
    grp_fill = '0;
  endtask

  // one accepted request: update the shadow state and queue what it yields
  task automatic predict_codec(input logic [7:0] c, input logic fin);
    logic [2:0] n;
    logic [6:0] sx;
    if (!decoding) begin
      dropping = 1'b0;
      if (grp_fill == 2'd3) clear_group();
      n = 3'(grp_fill) + 3'd1;
      grp_bits = grp_bits | ({16'b0, c} << (16 - 8 * grp_fill));
      if (n < 3'd3 && !fin) begin
        grp_fill = n[1:0];
      end else begin
        owe(sextet_char(grp_bits[23:18]), 1'b0, 1'b0);
        owe(sextet_char(grp_bits[17:12]), 1'b0, 1'b0);
        owe(n >= 3'd2 ? sextet_char(grp_bits[11:6]) : b64_pkg::PAD_CHAR, 1'b0, 1'b0);
        owe(n >= 3'd3 ? sextet_char(grp_bits[5:0]) : b64_pkg::PAD_CHAR, fin, 1'b0);
        clear_group();
      end
    end else if (dropping) begin
      if (fin) begin
        dropping = 1'b0;
        clear_group();
      end
    end else if (c == b64_pkg::PAD_CHAR && grp_fill >= 2'd2) begin
      if (grp_fill == 2'd2) begin
        owe(grp_bits[23:16], 1'b1, 1'b0);
      end else begin
        owe(grp_bits[23:16], 1'b0, 1'b0);
        owe(grp_bits[15:8], 1'b1, 1'b0);
      end
      clear_group();
      dropping = !fin;
    end else begin
      sx = char_sextet(c);
      if (sx[6] || (fin && grp_fill != 2'd3)) begin
        owe(8'h00, 1'b1, 1'b1);
        clear_group();
        dropping = !fin;
      end else begin
        grp_bits = grp_bits | ({18'b0, sx[5:0]} << (18 - 6 * grp_fill));
        if (grp_fill < 2'd3) begin
          grp_fill = grp_fill + 2'd1;
        end else begin
          owe(grp_bits[23:16], 1'b0, 1'b0);
          owe(grp_bits[15:8], 1'b0, 1'b0);
          owe(grp_bits[7:0], fin, 1'b0);
          clear_group();
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    codec_result_t want;
    if (rst) begin
      decoding = 1'b0;
      dropping = 1'b0;
      clear_group();
      owed_results.delete();
    end else begin
      // results first: a result never stems from a request taken at the same edge
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%t unexpected result: data %h last %b bad %b",
                     $realtime, m_tdata, m_tlast, m_tuser[0]);
        end else begin
          want = owed_results.pop_front();
          if (m_tdata !== want.data || m_tlast !== want.last || m_tuser[0] !== want.bad) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%t result mismatch: expected data %h last %b bad %b, got %h %b %b",
                       $realtime, want.data, want.last, want.bad,
                       m_tdata, m_tlast, m_tuser[0]);
          end
        end
      end
      if (cfg_wr_en) begin
        decoding = cfg_wr_data;
        dropping = 1'b0;
        clear_group();
      end
      if (s_tvalid && s_tready) predict_codec(s_tdata, s_tlast);
    end
    pending <= owed_results.size();
  end

endmodule

// File: tb/sv/base64_codec_tb.sv
// top of the base64 codec testbench: clock, reset, request stimulus and verdict
// depends on b64_pkg, base64_codec and base64_codec_checker

module base64_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  // cycles with no handshake on either side before the run is called hung;
  // far above the longest random stall of sender and receiver together
  localparam int STALL_LIMIT = 2000;
  // results pass the job queue and the back end after their request; keep margin
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [0:0] m_tuser;

  int         mismatches;
  int         pending;
  int         quiet_cycles = 0;
  // when set neither side idles
  logic       calm = 1'b0;

  codec_req_t reqs[$];

  always #4 clk = ~clk;

  base64_codec DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),      // [7:0] in_byte
    .s_tlast     (s_tlast),      // in_last
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),      // [7:0] out_byte
    .m_tlast     (m_tlast),      // out_last
    .m_tuser     (m_tuser)       // [0] bad_input
  );

  base64_codec_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  // result side back-pressure: ready drops about 16 percent of the time
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= calm || ($urandom_range(0, 99) >= 16);
  end

  // watchdog on progress: any accepted request or result restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[base64_codec] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_b64_char();
    int v;
    v = $urandom_range(0, 63);
    // the alphabet string holds 'A' in its top byte
    return b64_pkg::ALPHABET[(63 - v) * 8 +: 8];
  endfunction

  function automatic logic [7:0] rand_stray_char();
    logic [7:0]          c;
    b64_pkg::b64_sextet_t sx;
    do begin
      c = 8'($urandom_range(0, 255));
      sx = b64_pkg::b64_sextet(c);
    end while (sx.valid);
    return c;
  endfunction

  // one request, held until the codec takes it; ready is sampled mid-cycle
  // since the testbench only changes inputs at the rising edge
  task automatic send_req(input logic [7:0] data, input logic last);
    logic rdy;
    while (!calm && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic send_text(input string txt, input logic last);
    for (int i = 0; i < txt.len(); i++)
      send_req(txt[i], last && (i == txt.len() - 1));
  endtask

  task automatic send_queued();
    codec_req_t r;
    while (reqs.size() > 0) begin
      r = reqs.pop_front();
      send_req(r.data, r.last);
    end
  endtask

  // mode changes only once the codec has gone quiet
  task automatic set_mode(input logic mode);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    // a request with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random bytes to encode, ending on a marked last request
  task automatic queue_bytes();
    int         len;
    logic [7:0] b;
    len = $urandom_range(1, 9);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      reqs.push_back('{data: b, last: (i == len - 1)});
    end
  endtask

  // mostly well-formed text with random content, some broken or noise
  task automatic queue_text();
    int         groups;
    int         kind;
    int         n;
    logic [7:0] txt[$];
    groups = $urandom_range(0, 3);
    for (int i = 0; i < 4 * groups; i++) txt.push_back(rand_b64_char());
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        // complete final group
        repeat (4) txt.push_back(rand_b64_char());
      end
      4, 5: begin
        // pad as third character, fourth one is swallowed
        repeat (2) txt.push_back(rand_b64_char());
        txt.push_back(b64_pkg::PAD_CHAR);
        txt.push_back($urandom_range(0, 1) ? b64_pkg::PAD_CHAR : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(0, 255)));
      end
      6: begin
        // pad as fourth character, maybe trailing junk
        repeat (3) txt.push_back(rand_b64_char());
        txt.push_back(b64_pkg::PAD_CHAR);
        repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(0, 255)));
      end
      7: begin
        // bad character: outside the alphabet, or pad too early in a group
        n = $urandom_range(0, 3);
        repeat (n) txt.push_back(rand_b64_char());
        if (n < 2 && $urandom_range(0, 2) == 0) txt.push_back(b64_pkg::PAD_CHAR);
        else                                    txt.push_back(rand_stray_char());
        repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        // stream ends inside a group
        repeat ($urandom_range(1, 3)) txt.push_back(rand_b64_char());
      end
      default: begin
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    for (int i = 0; i < txt.size(); i++)
      reqs.push_back('{data: txt[i], last: (i == txt.size() - 1)});
  endtask

  initial begin
    logic mode;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed encode: one-byte and two-byte final groups, full group, byte extremes
    set_mode(MODE_ENCODE);
    send_req(8'h00, 1'b1);
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b1);
    send_req(8'hFF, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'hFF, 1'b1);

    // directed decode
    set_mode(MODE_DECODE);
    send_text("Az9/", 1'b1);   // alphabet edges, full group closing the stream
    send_text("QQ==", 1'b1);   // pad as third char, last request is dropped
    send_text("QUI=", 1'b0);   // pad as fourth char ...
    send_text("x", 1'b1);      // ... then junk up to the last request
    send_text("=", 1'b1);      // pad as first char is an error
    send_text("A*B", 1'b1);    // stray char, then the rest is swallowed
    send_text("AB", 1'b1);     // stream ends after two chars of a group

    // random phases, alternating modes; phases 2 and 3 run with no idling
    for (int ph = 0; ph < 8; ph++) begin
      mode = ph[0] ? MODE_DECODE : MODE_ENCODE;
      set_mode(mode);
      calm = (ph == 2 || ph == 3);
      while (reqs.size() < 34) begin
        if (mode == MODE_DECODE) queue_text();
        else                     queue_bytes();
      end
      // now and then leave the stream open so the mode write has to restart it
      if ($urandom_range(0, 2) == 0) reqs[reqs.size() - 1].last = 1'b0;
      send_queued();
      calm = 1'b0;
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[base64_codec] OK");
    end else begin
      $display("[base64_codec] ERROR");
    end
    $finish;
  end

endmodule
